// ===== hdl/group_sum_reducer_unit_defines.svh =====
// assertion macros for the group sum reducer
`ifndef GROUP_SUM_REDUCER_UNIT_DEFINES_SVH
`define GROUP_SUM_REDUCER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsr check failed");

// next-cycle implication, checked out of reset
`define GSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsr check failed");

`endif

// ===== hdl/gsr_pkg.sv =====
// types and codes shared by the group sum reducer modules
package gsr_pkg;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [31:0]        user_id;
    logic [55:0]        topic_hi;
    logic [55:0]        topic_lo;
    logic signed [15:0] action;
  } gsr_in_t;

  typedef struct packed {
    logic [31:0]        out_user;
    logic [55:0]        out_topic_hi;
    logic [55:0]        out_topic_lo;
    logic signed [31:0] total;
    logic               dropped;
    logic               last;
  } gsr_out_t;

  // contents of one table cell
  typedef struct packed {
    logic [55:0]        topic_hi;
    logic [55:0]        topic_lo;
    logic signed [31:0] total;
  } gsr_entry_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic               shift;
    logic               start;
    logic               add_en;
    logic               app_en;
    logic [55:0]        key_hi;
    logic [55:0]        key_lo;
    logic signed [15:0] score;
  } gsr_ctl_t;

endpackage

// ===== hdl/gsr_cell.sv =====
// one table cell: topic key, running saturated sum, key match and shift
module gsr_cell
  import gsr_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 6
) (
  input  logic             clk,
  input  gsr_ctl_t         ctl,
  input  logic [CNT_W-1:0] count,
  input  gsr_entry_t       next_data,
  output gsr_entry_t       data,
  output logic             hit
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);
  localparam logic             IS_HEAD = (CELL_IDX == 0);

  gsr_entry_t  data_r;
  gsr_entry_t  data_nxt;
  logic [32:0] sum_w;
  logic [31:0] sat_sum;
  logic [31:0] score_ext;

  assign data = data_r;
  assign hit  = (MY_IDX < count) && (data_r.topic_hi == ctl.key_hi) &&
                (data_r.topic_lo == ctl.key_lo);

  assign score_ext = {{16{ctl.score[15]}}, ctl.score};
  assign sum_w     = {data_r.total[31], data_r.total} + {score_ext[31], score_ext};

  always_comb begin
    // clamp when the two top bits disagree
    if (sum_w[32] != sum_w[31]) begin
      sat_sum = sum_w[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat_sum = sum_w[31:0];
    end
  end

  always_comb begin
    data_nxt = data_r;
    if (IS_HEAD && ctl.start) begin
      data_nxt.topic_hi = ctl.key_hi;
      data_nxt.topic_lo = ctl.key_lo;
      data_nxt.total    = score_ext;
    end else if (ctl.shift) begin
      data_nxt = next_data;
    end else if (ctl.add_en && hit) begin
      data_nxt.total = sat_sum;
    end else if (ctl.app_en && (MY_IDX == count)) begin
      data_nxt.topic_hi = ctl.key_hi;
      data_nxt.topic_lo = ctl.key_lo;
      data_nxt.total    = score_ext;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== hdl/group_sum_reducer_unit.sv =====
// group sum reducer top level: sequencer, cell chain and result register
// A record is accepted and then handled in a table update cycle in which every
// occupied cell compares its topic in parallel and the matching cell adds the
// score (or the next free cell takes the new topic; if the table is full, the
// record is dropped and flagged). A flush of n entries keeps busy high through
// the processing state and the flush state: the cell chain shifts one entry a
// cycle toward the head cell, whose entry goes to the result register, so the
// n results appear on consecutive cycles, one per beat. A record for a new user
// flushes the old group the same way and loads itself into the head cell on the
// final shift. An end of stream with an empty table gives no result. Results
// cannot be held off: out_valid is high for exactly one cycle per result.
`include "group_sum_reducer_unit_defines.svh"

module group_sum_reducer_unit
  import gsr_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  gsr_in_t  in_data,
  output logic     out_valid,
  output gsr_out_t out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_PROC, ST_FLUSH} state_t;

  state_t           state_r, state_nxt;
  gsr_in_t          req_r, req_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      user_r, user_nxt;
  logic             drop_r, drop_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  gsr_out_t         out_r, out_nxt;

  gsr_ctl_t         ctl;
  gsr_entry_t       cell_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit;
  logic             any_hit;
  logic             is_rec;
  logic             same_user;

  assign any_hit   = |hit;
  assign is_rec    = (state_r == ST_PROC) && (req_r.operation == OP_RECORD);
  assign same_user = is_rec && (count_r != '0) && (req_r.user_id == user_r);

  always_comb begin
    ctl.shift  = (state_r == ST_FLUSH);
    ctl.start  = (is_rec && (count_r == '0)) ||
                 ((state_r == ST_FLUSH) && (count_r == CNT_ONE) && pend_r);
    ctl.add_en = same_user;
    ctl.app_en = same_user && !any_hit && (count_r < CNT_FULL);
    ctl.key_hi = req_r.topic_hi;
    ctl.key_lo = req_r.topic_lo;
    ctl.score  = req_r.action;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    gsr_entry_t nxt_in;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nxt_in = cell_q[i];
    end else begin : g_body
      assign nxt_in = cell_q[i+1];
    end
    gsr_cell #(
      .CELL_IDX (i),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .next_data (nxt_in),
      .data      (cell_q[i]),
      .hit       (hit[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    user_nxt      = user_r;
    drop_nxt      = drop_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_data;
          state_nxt = ST_PROC;
        end
      end
      ST_PROC: begin
        state_nxt = ST_IDLE;
        if (req_r.operation == OP_FLUSH) begin
          if (count_r == '0) begin
            drop_nxt = 1'b0;
          end else begin
            pend_nxt  = 1'b0;
            state_nxt = ST_FLUSH;
          end
        end else if (count_r == '0) begin
          user_nxt  = req_r.user_id;
          count_nxt = CNT_ONE;
          drop_nxt  = 1'b0;
        end else if (!same_user) begin
          pend_nxt  = 1'b1;
          state_nxt = ST_FLUSH;
        end else if (ctl.app_en) begin
          count_nxt = count_r + CNT_ONE;
        end else if (!any_hit) begin
          drop_nxt = 1'b1;
        end
      end
      ST_FLUSH: begin
        out_valid_nxt        = 1'b1;
        out_nxt.out_user     = user_r;
        out_nxt.out_topic_hi = cell_q[0].topic_hi;
        out_nxt.out_topic_lo = cell_q[0].topic_lo;
        out_nxt.total        = cell_q[0].total;
        out_nxt.dropped      = drop_r;
        out_nxt.last         = (count_r == CNT_ONE);
        count_nxt            = count_r - CNT_ONE;
        if (count_r == CNT_ONE) begin
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
          // new user's first record went into the head cell on this shift
          if (pend_r) begin
            user_nxt  = req_r.user_id;
            count_nxt = CNT_ONE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      user_r      <= '0;
      drop_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      user_r      <= user_nxt;
      drop_r      <= drop_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `GSR_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_FULL)
  `GSR_ASSERT_IMPL(a_flush_nonempty, state_r == ST_FLUSH, count_r != '0)
  `GSR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `GSR_ASSERT_NEXT(a_beats_contiguous, out_valid && !out_data.last, out_valid)
  `GSR_ASSERT_NEXT(a_last_ends_group, out_valid && out_data.last, !out_valid)

endmodule
